### hdl/tlpc_pkg.sv
// ----------------------------------------------------------------------------
// tlpc_pkg: shared types and constants of the traffic light controller
// Phase codes, register indexes, reset values, the per-phase lamp table and
// the state, configuration and result records used by the core and its step.
// ----------------------------------------------------------------------------
package tlpc_pkg;

  localparam int unsigned N_LIGHTS = 5;
  localparam int unsigned LAMP_W   = 3 * N_LIGHTS;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;

  // Lamp offsets within one light's three bits.
  localparam int unsigned LAMP_GREEN  = 0;
  localparam int unsigned LAMP_YELLOW = 1;
  localparam int unsigned LAMP_RED    = 2;

  // Reset values.
  localparam logic [CFG_W-1:0]  SWITCH_TIME_RST = 16'd2000;
  localparam logic [CFG_W-1:0]  WALK_DELAY_RST  = 16'd1000;
  localparam logic [CFG_W-1:0]  PHASE_TIME_RST  = 16'd7000;
  localparam logic [LAMP_W-1:0] LAMPS_ALL_RED   = 15'h4924;

  typedef enum logic [2:0] {
    PH_DRIVE0     = 3'd0,
    PH_DRIVE1     = 3'd1,
    PH_DRIVE2     = 3'd2,
    PH_WALK_EAST  = 3'd3,
    PH_WALK_NORTH = 3'd4,
    PH_WALK_BOTH  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    REG_SWITCH_TIME = 2'd0,
    REG_WALK_DELAY  = 2'd1,
    REG_PHASE_TIME  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0] switch_time;
    logic [CFG_W-1:0] walk_delay;
    logic [CFG_W-1:0] phase_time;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]                clock_ms;
    logic [TIME_W-1:0]                phase_start_ms;
    phase_e                           current_phase;
    logic [1:0]                       last_drive;
    logic                             east_req;
    logic                             north_req;
    logic                             walk_pending;
    logic [N_LIGHTS-1:0]              goal_off;
    logic [N_LIGHTS-1:0]              in_trans;
    logic [N_LIGHTS-1:0][TIME_W-1:0]  deadline;
    logic [LAMP_W-1:0]                lamps;
    logic [1:0]                       walk;
  } state_t;

  typedef struct packed {
    logic [LAMP_W-1:0] vehicle_lamps;
    logic              east_walk;
    logic              north_walk;
    logic [2:0]        phase;
  } result_t;

  // Lights that are green in each phase (bit i is light i).
  function automatic logic [N_LIGHTS-1:0] phase_on_set(input phase_e ph);
    logic [N_LIGHTS-1:0] set;
    unique case (ph)
      PH_DRIVE0:     set = 5'h03;
      PH_DRIVE1:     set = 5'h0C;
      PH_DRIVE2:     set = 5'h12;
      PH_WALK_EAST:  set = 5'h05;
      PH_WALK_NORTH: set = 5'h02;
      PH_WALK_BOTH:  set = 5'h00;
      default:       set = 5'h00;
    endcase
    return set;
  endfunction

  function automatic logic is_walk_phase(input phase_e ph);
    return (ph == PH_WALK_EAST) || (ph == PH_WALK_NORTH) || (ph == PH_WALK_BOTH);
  endfunction

endpackage

### hdl/tlpc_tick_if.sv
// ----------------------------------------------------------------------------
// tlpc_tick_if: millisecond tick channel
// Carries one request per tick with the two pedestrian button levels.
// ----------------------------------------------------------------------------
interface tlpc_tick_if;
  logic valid;
  logic ready;
  logic east_button;
  logic north_button;

  modport source (output valid, output east_button, output north_button, input ready);
  modport sink   (input valid, input east_button, input north_button, output ready);
endinterface

### hdl/tlpc_result_if.sv
// ----------------------------------------------------------------------------
// tlpc_result_if: lamp result channel
// Carries one request per tick with the lamp pattern and the current phase.
// ----------------------------------------------------------------------------
interface tlpc_result_if;
  logic                        valid;
  logic                        ready;
  logic [tlpc_pkg::LAMP_W-1:0] vehicle_lamps;
  logic                        east_walk;
  logic                        north_walk;
  logic [2:0]                  phase;

  modport source (output valid, output vehicle_lamps, output east_walk,
                  output north_walk, output phase, input ready);
  modport sink   (input valid, input vehicle_lamps, input east_walk,
                  input north_walk, input phase, output ready);
endinterface

### hdl/tlpc_step.sv
// ----------------------------------------------------------------------------
// tlpc_step: next-state logic for one millisecond tick
// Settles due light transitions, latches buttons, updates the walk lamps and
// changes phase when it is due, producing the next state and the result.
// ----------------------------------------------------------------------------
module tlpc_step (
  input  tlpc_pkg::state_t  state_i,
  input  tlpc_pkg::cfg_t    cfg_i,
  input  logic              east_button_i,
  input  logic              north_button_i,
  output tlpc_pkg::state_t  state_o,
  output tlpc_pkg::result_t result_o
);
  import tlpc_pkg::*;

  logic [TIME_W-1:0]   t;
  logic [TIME_W-1:0]   switch_ext;
  logic [TIME_W-1:0]   walk_ext;
  logic [TIME_W-1:0]   phase_ext;
  logic [TIME_W-1:0]   walk_on_at;
  logic [TIME_W-1:0]   walk_off_at;
  logic [TIME_W-1:0]   phase_end_at;
  logic [TIME_W-1:0]   trans_len;
  logic [TIME_W-1:0]   new_deadline;
  logic [1:0]          drive_next;
  logic [N_LIGHTS-1:0] on_set;
  state_t              s;

  assign t            = state_i.clock_ms;
  assign switch_ext   = {{(TIME_W-CFG_W){1'b0}}, cfg_i.switch_time};
  assign walk_ext     = {{(TIME_W-CFG_W){1'b0}}, cfg_i.walk_delay};
  assign phase_ext    = {{(TIME_W-CFG_W){1'b0}}, cfg_i.phase_time};
  assign walk_on_at   = state_i.phase_start_ms + walk_ext + switch_ext;
  assign walk_off_at  = state_i.phase_start_ms + phase_ext - walk_ext;
  assign phase_end_at = state_i.phase_start_ms + phase_ext;
  // Transition takes one and a half switch times.
  assign trans_len    = switch_ext + {{(TIME_W-CFG_W+1){1'b0}}, cfg_i.switch_time[CFG_W-1:1]};
  assign new_deadline = t + trans_len;
  assign drive_next   = (state_i.last_drive >= 2'd2) ? 2'd0 : state_i.last_drive + 2'd1;

  always_comb begin
    s      = state_i;
    on_set = '0;

    // Finish every transition whose deadline has come.
    for (int i = 0; i < N_LIGHTS; i++) begin
      if (s.in_trans[i] && (t >= s.deadline[i])) begin
        if (s.goal_off[i]) begin
          s.lamps[3*i + LAMP_RED] = 1'b1;
        end else begin
          s.lamps[3*i + LAMP_RED]   = 1'b0;
          s.lamps[3*i + LAMP_GREEN] = 1'b1;
        end
        s.lamps[3*i + LAMP_YELLOW] = 1'b0;
        s.in_trans[i]              = 1'b0;
      end
    end

    // Latch pedestrian buttons, except for a walk already being served.
    if (s.current_phase != PH_WALK_BOTH) begin
      if (!s.east_req && (s.current_phase != PH_WALK_EAST)) begin
        s.east_req = east_button_i;
      end
      if (!s.north_req && (s.current_phase != PH_WALK_NORTH)) begin
        s.north_req = north_button_i;
      end
    end

    // Walk lamps come on after the delay and go dark ahead of the phase end.
    if (s.walk_pending && (t >= walk_on_at)) begin
      unique case (s.current_phase)
        PH_WALK_EAST:  s.walk = s.walk | 2'b01;
        PH_WALK_NORTH: s.walk = s.walk | 2'b10;
        PH_WALK_BOTH:  s.walk = 2'b11;
        default:       s.walk = s.walk;
      endcase
      s.walk_pending = 1'b0;
    end else if (!s.walk_pending && (t >= walk_off_at) && is_walk_phase(s.current_phase)) begin
      s.walk = 2'b00;
    end

    // Phase change: pedestrian requests first, otherwise the next driving phase.
    if (t >= phase_end_at) begin
      priority if (s.east_req && s.north_req) begin
        s.current_phase = PH_WALK_BOTH;
      end else if (s.east_req) begin
        s.current_phase = PH_WALK_EAST;
      end else if (s.north_req) begin
        s.current_phase = PH_WALK_NORTH;
      end else begin
        s.current_phase = phase_e'({1'b0, drive_next});
        s.last_drive    = drive_next;
      end

      on_set = phase_on_set(s.current_phase);
      for (int i = 0; i < N_LIGHTS; i++) begin
        if (s.in_trans[i] || (s.goal_off[i] == on_set[i])) begin
          s.goal_off[i]              = !on_set[i];
          s.in_trans[i]              = 1'b1;
          s.lamps[3*i + LAMP_YELLOW] = 1'b1;
          if (!on_set[i]) begin
            s.lamps[3*i + LAMP_GREEN] = 1'b0;
          end
          s.deadline[i] = new_deadline;
        end
      end

      s.phase_start_ms = t;
      if (is_walk_phase(s.current_phase)) begin
        s.walk_pending = 1'b1;
        s.east_req     = 1'b0;
        s.north_req    = 1'b0;
      end
    end

    s.clock_ms = t + 32'd1;
  end

  assign state_o                = s;
  assign result_o.vehicle_lamps = s.lamps;
  assign result_o.east_walk     = s.walk[0];
  assign result_o.north_walk    = s.walk[1];
  assign result_o.phase         = s.current_phase;

endmodule

### hdl/traffic_light_pedestrian_controller_core.sv
// ----------------------------------------------------------------------------
// traffic_light_pedestrian_controller_core: pedestrian-aware light controller
// Five vehicle lights and two walk lamps, advanced by one tick per request.
// ----------------------------------------------------------------------------
// Usage:
//   tick_i carries one request per millisecond with the east and north
//   button levels. For each accepted tick, result_o delivers one request
//   with the vehicle lamp pattern, both walk lamps and the phase as they
//   stand after that tick.
//   The whole tick update is one pass of logic from the state register to
//   the state and result registers, so a tick is taken every cycle while
//   tick_i.ready is high, and its result is registered along with the state.
//   The result side has a two-entry buffer (output register plus skid
//   register). While the receiver stalls, the buffer still takes ticks until
//   both entries hold a result; then tick_i.ready drops until the receiver
//   takes a result, and rises again in the cycle after that.
//   The APB port holds switch_time (0x0), walk_delay (0x4) and phase_time
//   (0x8); writes take effect on the next tick and should be done while no
//   tick is in flight. pready is always high.
//   Reset puts all lights at red, walk lamps dark, phase 2, clock at zero,
//   registers at their defaults, and empties the result buffer.
// ----------------------------------------------------------------------------
module traffic_light_pedestrian_controller_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tlpc_tick_if.sink                    tick_i,
  tlpc_result_if.source                result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tlpc_pkg::APB_AW-1:0]  paddr,
  input  logic [tlpc_pkg::APB_DW-1:0]  pwdata,
  output logic [tlpc_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import tlpc_pkg::*;

  cfg_t     cfg_q;
  state_t   state_q;
  state_t   state_d;
  result_t  step_res;
  result_t  out_q;
  result_t  skid_q;
  logic     out_valid_q;
  logic     skid_valid_q;
  logic     tick_acc;
  logic     out_pop;
  cfg_reg_e reg_sel;
  logic [N_LIGHTS-1:0] settled_ok;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.switch_time <= SWITCH_TIME_RST;
      cfg_q.walk_delay  <= WALK_DELAY_RST;
      cfg_q.phase_time  <= PHASE_TIME_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_SWITCH_TIME: cfg_q.switch_time <= pwdata[CFG_W-1:0];
        REG_WALK_DELAY:  cfg_q.walk_delay  <= pwdata[CFG_W-1:0];
        REG_PHASE_TIME:  cfg_q.phase_time  <= pwdata[CFG_W-1:0];
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (reg_sel)
      REG_SWITCH_TIME: prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_q.switch_time};
      REG_WALK_DELAY:  prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_q.walk_delay};
      REG_PHASE_TIME:  prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_q.phase_time};
      default:         prdata = '0;
    endcase
  end

  // Tick update.
  tlpc_step u_step (
    .state_i        (state_q),
    .cfg_i          (cfg_q),
    .east_button_i  (tick_i.east_button),
    .north_button_i (tick_i.north_button),
    .state_o        (state_d),
    .result_o       (step_res)
  );

  assign tick_i.ready = !skid_valid_q;
  assign tick_acc     = tick_i.valid && tick_i.ready;
  assign out_pop      = out_valid_q && result_o.ready;

  // Controller state advances once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.clock_ms       <= '0;
      state_q.phase_start_ms <= '0;
      state_q.current_phase  <= PH_DRIVE2;
      state_q.last_drive     <= 2'd2;
      state_q.east_req       <= 1'b0;
      state_q.north_req      <= 1'b0;
      state_q.walk_pending   <= 1'b0;
      state_q.goal_off       <= '1;
      state_q.in_trans       <= '0;
      state_q.deadline       <= '0;
      state_q.lamps          <= LAMPS_ALL_RED;
      state_q.walk           <= 2'b00;
    end else if (tick_acc) begin
      state_q <= state_d;
    end
  end

  // Result buffer: output register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else if (!tick_acc) begin
        out_valid_q <= 1'b0;
      end
    end else if (tick_acc) begin
      if (!out_valid_q) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (tick_acc) begin
        out_q <= step_res;
      end
    end else if (tick_acc) begin
      if (!out_valid_q) begin
        out_q <= step_res;
      end else begin
        skid_q <= step_res;
      end
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.vehicle_lamps = out_q.vehicle_lamps;
  assign result_o.east_walk     = out_q.east_walk;
  assign result_o.north_walk    = out_q.north_walk;
  assign result_o.phase         = out_q.phase;

  // A settled light shows exactly one of green and red, without yellow.
  always_comb begin
    for (int i = 0; i < N_LIGHTS; i++) begin
      settled_ok[i] = state_q.in_trans[i] ||
                      (!state_q.lamps[3*i + LAMP_YELLOW] &&
                       (state_q.lamps[3*i + LAMP_GREEN] ^ state_q.lamps[3*i + LAMP_RED]));
    end
  end

  // The skid register only holds a result behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register valid while output register empty");

  // Every accepted tick leaves a result waiting in the buffer.
  a_tick_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> out_valid_q)
    else $error("accepted tick produced no result");

  // The millisecond clock advances by one per accepted tick.
  a_clock_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> (state_q.clock_ms == $past(state_q.clock_ms) + 32'd1))
    else $error("clock did not advance by one tick");

  // Lights outside a transition show a clean green or red.
  a_settled_lamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    &settled_ok)
    else $error("settled light shows an invalid lamp pattern");

endmodule

### sim/traffic_light_pedestrian_controller_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// traffic_light_pedestrian_controller_core_test: self-checking bench of the core
// Feeds millisecond tick requests with random pedestrian button levels under
// many register settings and compares every lamp result, field by field,
// against a cycle-free model of the controller held in this bench.
// ----------------------------------------------------------------------------
module traffic_light_pedestrian_controller_core_test;
  import tlpc_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_TICKS = 1300;

  typedef struct packed {
    logic east;
    logic north;
  } button_sample_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tlpc_tick_if   tick_if ();
  tlpc_result_if result_if ();

  traffic_light_pedestrian_controller_core uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Button samples waiting to be offered, and lamp results still owed.
  button_sample_t button_backlog[$];
  result_t        lamp_forecast[$];

  // Controller model state and its copy of the registers.
  cfg_t                 ctl_cfg;
  logic [TIME_W-1:0]    ctl_clock;
  logic [TIME_W-1:0]    ctl_phase_start;
  phase_e               ctl_phase;
  logic [1:0]           ctl_last_drive;
  logic                 ctl_east_req;
  logic                 ctl_north_req;
  logic                 ctl_walk_pend;
  logic [N_LIGHTS-1:0]  ctl_goal_off;
  logic [N_LIGHTS-1:0]  ctl_in_trans;
  logic [TIME_W-1:0]    ctl_deadline [N_LIGHTS];
  logic [LAMP_W-1:0]    ctl_lamps;
  logic [1:0]           ctl_walk;

  // Handshake bookkeeping and run statistics.
  logic       tick_taken;
  int         burst_left;
  int         gap_left;
  int         rx_mode;
  int         rx_mode_left;
  int         hold_left;
  int         hold_count;
  int         fail_count;
  int         result_count;
  int         setting_count;
  int         walk_entries;
  logic [2:0] last_seen_phase;
  logic [7:0] phases_seen;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("traffic_light_pedestrian_controller_core_test: errors");
    $finish;
  end

  // Advance the controller model by one tick and return the lamp result.
  task automatic advance_controller(input logic east_b, input logic north_b,
                                    output result_t res);
    logic [TIME_W-1:0]   now;
    logic [TIME_W-1:0]   walk_on_at;
    logic [TIME_W-1:0]   walk_off_at;
    logic [TIME_W-1:0]   phase_end_at;
    logic [N_LIGHTS-1:0] green_set;
    logic                want_on;
    now = ctl_clock;

    // Lights whose transition time has come settle on red or green.
    for (int i = 0; i < N_LIGHTS; i++) begin
      if (now >= ctl_deadline[i] && ctl_in_trans[i]) begin
        if (ctl_goal_off[i]) begin
          ctl_lamps[3*i+LAMP_RED] = 1'b1;
        end else begin
          ctl_lamps[3*i+LAMP_RED]   = 1'b0;
          ctl_lamps[3*i+LAMP_GREEN] = 1'b1;
        end
        ctl_in_trans[i]            = 1'b0;
        ctl_lamps[3*i+LAMP_YELLOW] = 1'b0;
      end
    end

    // Buttons are latched except while their own walk phase runs.
    if (ctl_phase != PH_WALK_BOTH) begin
      if (!ctl_east_req && ctl_phase != PH_WALK_EAST) ctl_east_req = east_b;
      if (!ctl_north_req && ctl_phase != PH_WALK_NORTH) ctl_north_req = north_b;
    end

    // Walk lamps come on after the delay and go dark ahead of the phase end.
    walk_on_at  = ctl_phase_start + TIME_W'(ctl_cfg.walk_delay)
                  + TIME_W'(ctl_cfg.switch_time);
    walk_off_at = ctl_phase_start + TIME_W'(ctl_cfg.phase_time)
                  - TIME_W'(ctl_cfg.walk_delay);
    if (ctl_walk_pend && now >= walk_on_at) begin
      case (ctl_phase)
        PH_WALK_EAST:  ctl_walk = ctl_walk | 2'b01;
        PH_WALK_NORTH: ctl_walk = ctl_walk | 2'b10;
        PH_WALK_BOTH:  ctl_walk = ctl_walk | 2'b11;
        default: ;
      endcase
      ctl_walk_pend = 1'b0;
    end else if (!ctl_walk_pend && now >= walk_off_at && ctl_phase >= PH_WALK_EAST) begin
      ctl_walk = 2'b00;
    end

    // Phase change: walk requests first, otherwise the next driving phase.
    phase_end_at = ctl_phase_start + TIME_W'(ctl_cfg.phase_time);
    if (now >= phase_end_at) begin
      if (ctl_east_req && ctl_north_req) begin
        ctl_phase = PH_WALK_BOTH;
      end else if (ctl_east_req) begin
        ctl_phase = PH_WALK_EAST;
      end else if (ctl_north_req) begin
        ctl_phase = PH_WALK_NORTH;
      end else begin
        ctl_last_drive = (ctl_last_drive >= 2'd2) ? 2'd0 : ctl_last_drive + 2'd1;
        ctl_phase      = phase_e'({1'b0, ctl_last_drive});
      end
      case (ctl_phase)
        PH_DRIVE0:     green_set = 5'h03;
        PH_DRIVE1:     green_set = 5'h0C;
        PH_DRIVE2:     green_set = 5'h12;
        PH_WALK_EAST:  green_set = 5'h05;
        PH_WALK_NORTH: green_set = 5'h02;
        default:       green_set = 5'h00;
      endcase
      // A light already settled where it should be is left alone; any other
      // light shows yellow and (re)starts its transition.
      for (int i = 0; i < N_LIGHTS; i++) begin
        want_on = green_set[i];
        if (ctl_in_trans[i] || ctl_goal_off[i] != !want_on) begin
          ctl_goal_off[i]            = !want_on;
          ctl_in_trans[i]            = 1'b1;
          ctl_lamps[3*i+LAMP_YELLOW] = 1'b1;
          if (!want_on) ctl_lamps[3*i+LAMP_GREEN] = 1'b0;
          ctl_deadline[i] = now + TIME_W'(ctl_cfg.switch_time >> 1)
                            + TIME_W'(ctl_cfg.switch_time);
        end
      end
      ctl_phase_start = now;
      if (ctl_phase >= PH_WALK_EAST) begin
        ctl_walk_pend = 1'b1;
        ctl_east_req  = 1'b0;
        ctl_north_req = 1'b0;
      end else begin
        ctl_last_drive = ctl_phase[1:0];
      end
    end

    res.vehicle_lamps = ctl_lamps;
    res.east_walk     = ctl_walk[0];
    res.north_walk    = ctl_walk[1];
    res.phase         = ctl_phase;
    ctl_clock         = now + 32'd1;
  endtask

  task automatic flag_error(input string what, input logic [31:0] want,
                            input logic [31:0] got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("mismatch after %0d results: %s expected 0x%0h got 0x%0h",
               result_count, what, want, got);
    end
  endtask

  // APB write: setup cycle, then access cycle.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SWITCH_TIME: ctl_cfg.switch_time = data[CFG_W-1:0];
      REG_WALK_DELAY:  ctl_cfg.walk_delay  = data[CFG_W-1:0];
      REG_PHASE_TIME:  ctl_cfg.phase_time  = data[CFG_W-1:0];
      default: ;
    endcase
  endtask

  // APB read, compared with the model's copy of the register.
  task automatic reg_check(input logic [1:0] idx, input logic [CFG_W-1:0] want);
    logic [31:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[CFG_W-1:0] !== want) flag_error("register readback", 32'(want), got);
  endtask

  // Program all registers while the core is idle and read them back.
  task automatic apply_setting(input logic [CFG_W-1:0] st, input logic [CFG_W-1:0] wd,
                               input logic [CFG_W-1:0] pt);
    reg_write(REG_SWITCH_TIME, {16'($urandom_range(0, 65535)), st});
    reg_write(REG_WALK_DELAY, {16'($urandom_range(0, 65535)), wd});
    reg_write(REG_PHASE_TIME, {16'($urandom_range(0, 65535)), pt});
    // The unused address must leave every register untouched.
    if ($urandom_range(0, 2) == 0) reg_write(REG_UNUSED, $urandom);
    reg_check(REG_SWITCH_TIME, ctl_cfg.switch_time);
    reg_check(REG_WALK_DELAY, ctl_cfg.walk_delay);
    reg_check(REG_PHASE_TIME, ctl_cfg.phase_time);
    setting_count++;
  endtask

  // Hold off until every queued request has been taken and answered.
  task automatic drain_ticks();
    @(posedge clk_i);
    while (button_backlog.size() != 0 || tick_if.valid || lamp_forecast.size() != 0)
      @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic button_sample_t random_buttons(input int mode);
    button_sample_t s;
    case (mode)
      0: begin
        s.east  = ($urandom_range(0, 99) < 1);
        s.north = ($urandom_range(0, 99) < 1);
      end
      1: begin
        s.east  = ($urandom_range(0, 99) < 30);
        s.north = ($urandom_range(0, 99) < 2);
      end
      2: begin
        s.east  = ($urandom_range(0, 99) < 2);
        s.north = ($urandom_range(0, 99) < 30);
      end
      3: begin
        s.east  = ($urandom_range(0, 99) < 40);
        s.north = ($urandom_range(0, 99) < 40);
      end
      default: begin
        s.east  = 1'($urandom_range(0, 1));
        s.north = 1'($urandom_range(0, 1));
      end
    endcase
    return s;
  endfunction

  // Tick driver: bursts of requests with random gaps, holding until taken.
  always @(negedge clk_i) begin
    button_sample_t s;
    if (!rst_ni) begin
      tick_if.valid        <= 1'b0;
      tick_if.east_button  <= 1'b0;
      tick_if.north_button <= 1'b0;
      burst_left           <= 1;
      gap_left             <= 0;
    end else if (tick_if.valid && !tick_taken) begin
      // Request still waiting for ready.
    end else if (gap_left != 0) begin
      tick_if.valid        <= 1'b0;
      tick_if.east_button  <= 1'($urandom_range(0, 1));
      tick_if.north_button <= 1'($urandom_range(0, 1));
      gap_left             <= gap_left - 1;
    end else if (button_backlog.size() != 0) begin
      s = button_backlog.pop_front();
      tick_if.valid        <= 1'b1;
      tick_if.east_button  <= s.east;
      tick_if.north_button <= s.north;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 30);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      tick_if.valid <= 1'b0;
    end
  end

  // Result receiver: changing stall patterns plus up to two long hold-offs.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      rx_mode         <= 0;
      rx_mode_left    <= 0;
      hold_left       <= 0;
      hold_count      <= 0;
    end else if (hold_left != 0) begin
      result_if.ready <= 1'b0;
      hold_left       <= hold_left - 1;
    end else if (hold_count < 2 && result_count >= (hold_count == 0 ? 300 : 900)
                 && button_backlog.size() > 20) begin
      result_if.ready <= 1'b0;
      hold_left       <= 80;
      hold_count      <= hold_count + 1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(10, 60);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0:       result_if.ready <= 1'b1;
        1:       result_if.ready <= 1'($urandom_range(0, 1));
        2:       result_if.ready <= ($urandom_range(0, 3) == 0);
        default: result_if.ready <= (rx_mode_left % 3 == 0);
      endcase
    end
  end

  // Monitor: check each result against the oldest forecast, then forecast
  // the result of any tick request taken at this edge.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    result_t next_res;
    if (!rst_ni) begin
      tick_taken <= 1'b0;
    end else begin
      tick_taken <= tick_if.valid && tick_if.ready;
      if (result_if.valid && result_if.ready) begin
        got.vehicle_lamps = result_if.vehicle_lamps;
        got.east_walk     = result_if.east_walk;
        got.north_walk    = result_if.north_walk;
        got.phase         = result_if.phase;
        if (lamp_forecast.size() == 0) begin
          flag_error("result with no tick pending", 32'd0, 32'(got));
        end else begin
          want = lamp_forecast.pop_front();
          if (got.vehicle_lamps !== want.vehicle_lamps)
            flag_error("vehicle_lamps", 32'(want.vehicle_lamps), 32'(got.vehicle_lamps));
          if (got.east_walk !== want.east_walk)
            flag_error("east_walk", 32'(want.east_walk), 32'(got.east_walk));
          if (got.north_walk !== want.north_walk)
            flag_error("north_walk", 32'(want.north_walk), 32'(got.north_walk));
          if (got.phase !== want.phase)
            flag_error("phase", 32'(want.phase), 32'(got.phase));
        end
        result_count++;
        phases_seen[got.phase] = 1'b1;
        if (got.phase >= PH_WALK_EAST && got.phase != last_seen_phase) walk_entries++;
        last_seen_phase = got.phase;
      end
      if (tick_if.valid && tick_if.ready) begin
        advance_controller(tick_if.east_button, tick_if.north_button, next_res);
        lamp_forecast.push_back(next_res);
      end
    end
  end

  // Stimulus sequence.
  initial begin
    int               queued;
    int               seg;
    int               n;
    int               mode;
    logic [CFG_W-1:0] st;
    logic [CFG_W-1:0] wd;
    logic [CFG_W-1:0] pt;

    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    fail_count           = 0;
    result_count         = 0;
    setting_count        = 0;
    walk_entries         = 0;
    last_seen_phase      = PH_DRIVE2;
    phases_seen          = '0;

    // Model state after reset.
    ctl_cfg.switch_time = SWITCH_TIME_RST;
    ctl_cfg.walk_delay  = WALK_DELAY_RST;
    ctl_cfg.phase_time  = PHASE_TIME_RST;
    ctl_clock           = '0;
    ctl_phase_start     = '0;
    ctl_phase           = PH_DRIVE2;
    ctl_last_drive      = 2'd2;
    ctl_east_req        = 1'b0;
    ctl_north_req       = 1'b0;
    ctl_walk_pend       = 1'b0;
    ctl_goal_off        = '1;
    ctl_in_trans        = '0;
    for (int i = 0; i < N_LIGHTS; i++) ctl_deadline[i] = '0;
    ctl_lamps           = LAMPS_ALL_RED;
    ctl_walk            = 2'b00;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values of the registers, then a few ticks with them.
    reg_check(REG_SWITCH_TIME, ctl_cfg.switch_time);
    reg_check(REG_WALK_DELAY, ctl_cfg.walk_delay);
    reg_check(REG_PHASE_TIME, ctl_cfg.phase_time);
    button_backlog.push_back('{1'b0, 1'b0});
    button_backlog.push_back('{1'b1, 1'b1});
    button_backlog.push_back('{1'b1, 1'b0});
    button_backlog.push_back('{1'b0, 1'b1});
    drain_ticks();

    // Zero phase length: a phase change on every tick.
    apply_setting(16'd0, 16'd0, 16'd0);
    for (int i = 0; i < 6; i++) button_backlog.push_back('{i[0], i[1]});
    drain_ticks();

    // Walk phase shorter than its lamp delay, lights caught mid-transition.
    apply_setting(16'd4, 16'd5, 16'd3);
    for (int i = 0; i < 8; i++) button_backlog.push_back('{1'b1, 1'b0});
    drain_ticks();

    // Both walk requests at once with short timing.
    apply_setting(16'd1, 16'd1, 16'd6);
    for (int i = 0; i < 8; i++) button_backlog.push_back('{i < 4, i < 4});
    drain_ticks();

    // Random part: many settings, extremes first, mostly short timings.
    queued = 0;
    seg    = 0;
    while (queued < RANDOM_TICKS) begin
      n    = $urandom_range(40, 120);
      mode = $urandom_range(0, 4);
      case (seg)
        0: begin
          st = 16'hFFFF;
          wd = 16'($urandom_range(0, 8));
          pt = 16'($urandom_range(1, 30));
          n  = 40;
        end
        1: begin
          st = 16'($urandom_range(0, 6));
          wd = 16'hFFFF;
          pt = 16'hFFFF;
          n  = 40;
        end
        2: begin
          st = 16'd0;
          wd = 16'd0;
          pt = 16'd1;
        end
        default: begin
          if ($urandom_range(0, 9) == 0) begin
            // Phase shorter than the walk delay.
            st = 16'($urandom_range(0, 6));
            wd = 16'($urandom_range(5, 20));
            pt = 16'($urandom_range(0, 4));
          end else begin
            st = 16'($urandom_range(0, 6));
            wd = 16'($urandom_range(0, 6));
            pt = 16'($urandom_range(1, 40));
          end
        end
      endcase
      apply_setting(st, wd, pt);
      for (int i = 0; i < n; i++) button_backlog.push_back(random_buttons(mode));
      queued += n;
      seg++;
      drain_ticks();
    end

    if (lamp_forecast.size() != 0) begin
      flag_error("results never delivered", 32'd0, 32'(lamp_forecast.size()));
    end
    $display("Checked %0d tick results over %0d register settings, %0d walk phases.",
             result_count, setting_count, walk_entries);
    $display("Phases observed (bit per phase): 0x%0h, long receiver hold-offs: %0d.",
             phases_seen, hold_count);
    if (fail_count == 0) begin
      $display("traffic_light_pedestrian_controller_core_test: clean");
    end else begin
      $display("traffic_light_pedestrian_controller_core_test: errors");
    end
    $finish;
  end

endmodule
